// ----- src/ntt_pkg.sv -----
// shared constants for the radix-2 ntt block
`timescale 1ns / 1ps
package ntt_pkg;
    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam logic [29:0] PRIME = 30'd998244353;
    localparam int VAL_W = 30;
    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [2:0] ADDR_LOG = 3'd4;

    // the shared multiplier folds a conditional subtraction of the prime
    // into every shift-add step, so no wide product is ever formed
endpackage

// ----- src/ntt_mulmod.sv -----
// multi-cycle modular multiplier: shift-add, one bit per cycle
`timescale 1ns / 1ps
module ntt_mulmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [29:0] a,
    input  logic [29:0] b,
    output logic        done,
    output logic [29:0] y
);
    import ntt_pkg::*;
    logic [29:0] a_reg, a_next, acc_reg, acc_next;
    logic [29:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next, done_reg, done_next;
    logic [30:0] dbl, dbl_r, sum, sum_r;

    // acc = 2*acc + bit*a, all mod p, msb first
    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
        sum   = dbl_r + (b_reg[29] ? {1'b0, a_reg} : 31'd0);
        sum_r = (sum >= {1'b0, PRIME}) ? sum - {1'b0, PRIME} : sum;
        a_next = a_reg; b_next = b_reg; acc_next = acc_reg;
        cnt_next = cnt_reg; run_next = run_reg; done_next = 1'b0;
        if (go)
        begin
            a_next = a; b_next = b; acc_next = '0; cnt_next = '0; run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = sum_r[29:0];
            b_next = {b_reg[28:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29)
            begin
                run_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; b_reg <= b_next; acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign y    = acc_reg;
endmodule

// ----- src/ntt_radix2_mod998244353.sv -----
// top level: coefficient store, sequencer and apb registers
//  channel | signals                         | note
//  input   | start, busy, coefficient        | beat when start && !busy
//  output  | valid, value, last              | one-cycle strobe, no stall
//  config  | psel penable pwrite paddr pwdata prdata pready
// the beat that completes a load of N points starts the transform.
// a modular multiply holds the shared unit from the go strobe until done.
// bit reversal swaps each index with its reverse; each stage root takes two multiplies
// per exponent bit, with 30-log2(len) exponent bits forward and up to 30 bits inverse.
// a butterfly uses two multiplies, inverse mode scales each point by n^-1, then N output strobes.
// reset clears control state; the store is undefined until written; busy falls with the last strobe.
`timescale 1ns / 1ps
module ntt_radix2_mod998244353 #(
    parameter int unsigned MAX_POINTS = ntt_pkg::MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [29:0] coefficient,
    output logic        valid,
    output logic [29:0] value,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ntt_pkg::*;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int MAXLG = $clog2(MAX_POINTS + 1) - 1;

    typedef enum logic [3:0] {
        S_LOAD, S_REV, S_WN, S_WN_WAIT, S_RD, S_MUL, S_MUL_WAIT,
        S_WR, S_TW_WAIT, S_SCALE, S_SCALE_WAIT, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic        inv_reg;
    logic [2:0]  lg_cfg_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic [29:0] store [MAX_POINTS];
    logic [29:0] wn_reg, wn_next, tw_reg, tw_next, u_reg, u_next, t_reg, t_next;
    logic [29:0] pw_base_reg, pw_base_next;
    logic [AW:0] i_reg, i_next;
    logic [AW:0] len_reg, len_next, base_reg, base_next, k_reg, k_next;
    logic [29:0] e_reg, e_next;
    logic [1:0]  ph_reg, ph_next;
    logic        valid_reg, last_reg;
    logic [29:0] rda_reg, rdb_reg;
    logic [AW-1:0] ra, rb;
    logic [2:0]  lg_act;
    logic [AW:0] n;
    logic        mgo;
    logic [29:0] ma, mb, my;
    logic        mdone;
    logic        we;
    logic [AW-1:0] waddr;
    logic [29:0] wdata;
    logic [29:0] coef_r;
    logic [AW-1:0] lo, hi, rev;
    logic [29:0] e_stage;
    logic [30:0] s_add, s_sub;
    logic        eflag_reg, eflag_next;

    // active log length
    always_comb
    begin
        lg_act = (lg_cfg_reg == 3'd0) ? 3'd1 : (lg_cfg_reg == 3'd7) ? 3'd6 : lg_cfg_reg;
        if (lg_act > 3'(MAXLG)) lg_act = 3'(MAXLG);
        if (lg_act == 3'd0) lg_act = 3'd1;
        n = (AW+1)'(1) << lg_act;
        coef_r = (coefficient >= PRIME) ? coefficient - PRIME : coefficient;
        lo = AW'(base_reg + k_reg);
        hi = AW'(base_reg + k_reg + (len_reg >> 1));
        rev = '0;
        for (int b = 0; b < AW; b++)
            if (b < int'(lg_act)) rev[int'(lg_act) - 1 - b] = i_reg[b];
        // (p-1)/len for a power-of-two stage length
        e_stage = '0;
        for (int s = 1; s <= AW; s++)
            if (len_reg == ((AW+1)'(1) << s)) e_stage = 30'd998244352 >> s;
    end

    ntt_mulmod u_mul (
        .clk(clk), .rst_n(rst_n), .go(mgo), .a(ma), .b(mb), .done(mdone), .y(my)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg; cnt_next = cnt_reg; wn_next = wn_reg; tw_next = tw_reg;
        u_next = u_reg; t_next = t_reg; i_next = i_reg; len_next = len_reg;
        base_next = base_reg; k_next = k_reg; e_next = e_reg; ph_next = ph_reg;
        pw_base_next = pw_base_reg; eflag_next = eflag_reg;
        mgo = 1'b0; ma = '0; mb = '0; we = 1'b0; waddr = '0; wdata = '0;
        ra = '0; rb = '0;
        s_add = {1'b0, u_reg} + {1'b0, t_reg};
        s_add = (s_add >= {1'b0, PRIME}) ? s_add - {1'b0, PRIME} : s_add;
        s_sub = {1'b0, u_reg} + {1'b0, PRIME} - {1'b0, t_reg};
        s_sub = (s_sub >= {1'b0, PRIME}) ? s_sub - {1'b0, PRIME} : s_sub;
        case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    we = 1'b1; waddr = AW'(cnt_reg); wdata = coef_r;
                    cnt_next = cnt_reg + 7'd1;
                    if ((cnt_reg + 7'd1) >= 7'(n))
                    begin
                        cnt_next = '0; i_next = '0; ph_next = '0;
                        state_next = S_REV;
                    end
                end
            end
            S_REV:
            begin
                // three-phase swap: read both, write low, write high
                if (ph_reg == 2'd0)
                begin
                    ra = AW'(i_reg); rb = rev;
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    u_next = rda_reg;
                    if (AW'(i_reg) < rev)
                    begin
                        we = 1'b1; waddr = AW'(i_reg); wdata = rdb_reg;
                    end
                    ph_next = 2'd2;
                end
                else
                begin
                    if (AW'(i_reg) < rev)
                    begin
                        we = 1'b1; waddr = rev; wdata = u_reg;
                    end
                    ph_next = 2'd0;
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == n)
                    begin
                        len_next = (AW+1)'(2); state_next = S_WN;
                    end
                end
            end
            S_WN:
            begin
                // wn = 3^e by square-and-multiply, e = (p-1)/len or p-1-that
                e_next = inv_reg ? (PRIME - 30'd1) - e_stage : e_stage;
                wn_next = 30'd1; pw_base_next = 30'd3; ph_next = 2'd0;
                state_next = S_WN_WAIT; eflag_next = 1'b0;
            end
            S_WN_WAIT:
            begin
                if (!eflag_reg)
                begin
                    if (e_reg == '0)
                    begin
                        tw_next = 30'd1; base_next = '0; k_next = '0; state_next = S_RD;
                    end
                    else
                    begin
                        mgo = 1'b1; eflag_next = 1'b1;
                        if (ph_reg == 2'd0)
                        begin
                            ma = pw_base_reg; mb = e_reg[0] ? wn_reg : 30'd1;
                        end
                        else
                        begin
                            ma = pw_base_reg; mb = pw_base_reg;
                        end
                    end
                end
                else if (mdone)
                begin
                    eflag_next = 1'b0;
                    if (ph_reg == 2'd0)
                    begin
                        if (e_reg[0]) wn_next = my;
                        ph_next = 2'd1;
                    end
                    else
                    begin
                        pw_base_next = my; e_next = e_reg >> 1; ph_next = 2'd0;
                    end
                end
            end
            S_RD:
            begin
                ra = lo; rb = hi;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                u_next = rda_reg;
                mgo = 1'b1; ma = tw_reg; mb = rdb_reg; state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mdone)
                begin
                    t_next = my; state_next = S_WR; ph_next = 2'd0;
                end
            end
            S_WR:
            begin
                if (ph_reg == 2'd0)
                begin
                    we = 1'b1; waddr = hi; wdata = s_sub[29:0]; ph_next = 2'd1;
                end
                else
                begin
                    we = 1'b1; waddr = lo; wdata = s_add[29:0];
                    mgo = 1'b1; ma = tw_reg; mb = wn_reg; state_next = S_TW_WAIT;
                end
            end
            S_TW_WAIT:
            begin
                if (mdone)
                begin
                    tw_next = my; state_next = S_RD;
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == (len_reg >> 1))
                    begin
                        k_next = '0; tw_next = 30'd1;
                        base_next = base_reg + len_reg;
                        if (base_reg + len_reg >= n)
                        begin
                            base_next = '0;
                            len_next = len_reg << 1;
                            if (len_reg == n)
                            begin
                                i_next = '0; tw_next = 30'd1; ph_next = 2'd0;
                                if (inv_reg)
                                begin
                                    // n^-1 = p - (p-1)/n
                                    wn_next = PRIME - 30'(30'd998244352 >> lg_act);
                                    state_next = S_SCALE;
                                end
                                else
                                    state_next = S_OUT;
                            end
                            else
                                state_next = S_WN;
                        end
                    end
                end
            end
            S_SCALE:
            begin
                if (ph_reg == 2'd0)
                begin
                    ra = AW'(i_reg); ph_next = 2'd1;
                end
                else
                begin
                    mgo = 1'b1; ma = rda_reg; mb = wn_reg; ph_next = 2'd0;
                    state_next = S_SCALE_WAIT;
                end
            end
            S_SCALE_WAIT:
            begin
                if (mdone)
                begin
                    we = 1'b1; waddr = AW'(i_reg); wdata = my;
                    i_next = i_reg + 1'b1; state_next = S_SCALE;
                    if (i_reg + 1'b1 == n)
                    begin
                        i_next = '0; state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                ra = AW'(i_reg);
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == n)
                begin
                    i_next = '0; state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD; cnt_reg <= '0; valid_reg <= 1'b0; last_reg <= 1'b0;
            inv_reg <= 1'b0; lg_cfg_reg <= 3'd6; i_reg <= '0; len_reg <= '0;
            base_reg <= '0; k_reg <= '0; ph_reg <= '0; eflag_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; cnt_reg <= cnt_next;
            i_reg <= i_next; len_reg <= len_next; base_reg <= base_next;
            k_reg <= k_next; ph_reg <= ph_next; eflag_reg <= eflag_next;
            valid_reg <= (state_reg == S_OUT);
            last_reg  <= (state_reg == S_OUT) && (i_reg + 1'b1 == n);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_MODE) inv_reg <= pwdata[0];
                else if (paddr == ADDR_LOG) lg_cfg_reg <= pwdata[2:0];
            end
        end
    end

    // payload and memory, two registered read ports
    always_ff @(posedge clk)
    begin
        wn_reg <= wn_next; tw_reg <= tw_next; u_reg <= u_next; t_reg <= t_next;
        e_reg <= e_next; pw_base_reg <= pw_base_next;
        rda_reg <= store[ra];
        rdb_reg <= store[rb];
        if (we) store[waddr] <= wdata;
    end

    assign busy   = (state_reg != S_LOAD);
    assign valid  = valid_reg;
    assign value  = rda_reg;
    assign last   = last_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LOG) ? {29'd0, lg_cfg_reg} :
                    (paddr == ADDR_MODE) ? {31'd0, inv_reg} : 32'd0;
endmodule
